### hdl/c65_pkg.sv
// Shared types, operation codes and flag positions for the 6502 execute unit.
`timescale 1ns / 1ps
`default_nettype none

package c65_pkg;

    // Operation codes of the decoded input request.
    localparam logic [5:0] F_ORA = 6'd0;
    localparam logic [5:0] F_AND = 6'd1;
    localparam logic [5:0] F_EOR = 6'd2;
    localparam logic [5:0] F_ADC = 6'd3;
    localparam logic [5:0] F_SBC = 6'd4;
    localparam logic [5:0] F_CMP = 6'd5;
    localparam logic [5:0] F_CPX = 6'd6;
    localparam logic [5:0] F_CPY = 6'd7;
    localparam logic [5:0] F_BIT = 6'd8;
    localparam logic [5:0] F_LDA = 6'd9;
    localparam logic [5:0] F_LDX = 6'd10;
    localparam logic [5:0] F_LDY = 6'd11;
    localparam logic [5:0] F_STA = 6'd12;
    localparam logic [5:0] F_STX = 6'd13;
    localparam logic [5:0] F_STY = 6'd14;
    localparam logic [5:0] F_ASL = 6'd15;
    localparam logic [5:0] F_ROL = 6'd16;
    localparam logic [5:0] F_LSR = 6'd17;
    localparam logic [5:0] F_ROR = 6'd18;
    localparam logic [5:0] F_INC = 6'd19;
    localparam logic [5:0] F_DEC = 6'd20;
    localparam logic [5:0] F_PHA = 6'd21;
    localparam logic [5:0] F_PHP = 6'd22;
    localparam logic [5:0] F_PLA = 6'd23;
    localparam logic [5:0] F_PLP = 6'd24;
    localparam logic [5:0] F_TAX = 6'd25;
    localparam logic [5:0] F_TAY = 6'd26;
    localparam logic [5:0] F_TXA = 6'd27;
    localparam logic [5:0] F_TYA = 6'd28;
    localparam logic [5:0] F_TSX = 6'd29;
    localparam logic [5:0] F_TXS = 6'd30;
    localparam logic [5:0] F_INX = 6'd31;
    localparam logic [5:0] F_INY = 6'd32;
    localparam logic [5:0] F_DEX = 6'd33;
    localparam logic [5:0] F_DEY = 6'd34;
    localparam logic [5:0] F_CLC = 6'd35;
    localparam logic [5:0] F_SEC = 6'd36;
    localparam logic [5:0] F_CLI = 6'd37;
    localparam logic [5:0] F_SEI = 6'd38;
    localparam logic [5:0] F_CLD = 6'd39;
    localparam logic [5:0] F_SED = 6'd40;
    localparam logic [5:0] F_CLV = 6'd41;
    localparam logic [5:0] F_BPL = 6'd42;
    localparam logic [5:0] F_BMI = 6'd43;
    localparam logic [5:0] F_BVC = 6'd44;
    localparam logic [5:0] F_BVS = 6'd45;
    localparam logic [5:0] F_BCC = 6'd46;
    localparam logic [5:0] F_BCS = 6'd47;
    localparam logic [5:0] F_BNE = 6'd48;
    localparam logic [5:0] F_BEQ = 6'd49;
    localparam logic [5:0] F_NOP = 6'd50;

    // Bit positions in the flag byte.
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // Register values after reset.
    localparam logic [7:0] RESET_SP    = 8'hFD;
    localparam logic [7:0] RESET_FLAGS = 8'h24;

    typedef struct packed {
        logic [5:0] func;
        logic [7:0] operand;
        logic       on_accumulator;
    } t_c65_in;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] index_x;
        logic [7:0] index_y;
        logic [7:0] stack_ptr;
        logic [7:0] status;
        logic       write_valid;
        logic [7:0] write_data;
        logic       to_stack;
        logic [7:0] stack_slot;
        logic       branch_taken;
    } t_c65_out;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] flags;
    } t_c65_state;

endpackage

`default_nettype wire

### hdl/c65_exec.sv
// Single-pass ALU and register update logic of the 6502 execute unit.
`timescale 1ns / 1ps
`default_nettype none

module c65_exec (
    input  c65_pkg::t_c65_in    i_req,
    input  c65_pkg::t_c65_state i_state,
    output c65_pkg::t_c65_state o_state,
    output c65_pkg::t_c65_out   o_result
);
    import c65_pkg::*;

    logic [7:0] m;
    logic       cin;
    logic [7:0] addend;
    logic [8:0] sum;
    logic [7:0] cmp_reg;
    logic [8:0] diff;
    logic [7:0] shift_src;
    logic       shift_left;
    logic [7:0] shift_res;
    logic       shift_c;
    logic [7:0] inc_res;
    logic [7:0] dec_res;

    logic       wv;
    logic [7:0] wd;
    logic       stk;
    logic [7:0] slot;
    logic       taken;
    t_c65_state nxt;

    // Returns the flag byte with Z and N taken from a result value.
    function automatic logic [7:0] f_zn(input logic [7:0] flags, input logic [7:0] val);
        logic [7:0] f;
        f = flags;
        f[FLAG_Z] = (val == 8'd0);
        f[FLAG_N] = val[7];
        return f;
    endfunction

    assign m   = i_req.operand;
    assign cin = i_state.flags[FLAG_C];

    // Shared adder for ADC and SBC; SBC adds the inverted operand.
    assign addend = (i_req.func == F_SBC) ? ~m : m;
    assign sum    = {1'b0, i_state.acc} + {1'b0, addend} + {8'd0, cin};

    // Shared subtractor for the three compares.
    assign cmp_reg = (i_req.func == F_CPX) ? i_state.x :
                     (i_req.func == F_CPY) ? i_state.y : i_state.acc;
    assign diff    = {1'b0, cmp_reg} - {1'b0, m};

    // Shifter for ASL, ROL, LSR and ROR on A or on memory.
    assign shift_src  = i_req.on_accumulator ? i_state.acc : m;
    assign shift_left = (i_req.func == F_ASL) || (i_req.func == F_ROL);
    assign shift_res  = shift_left ?
                        {shift_src[6:0], (i_req.func == F_ROL) & cin} :
                        {(i_req.func == F_ROR) & cin, shift_src[7:1]};
    assign shift_c    = shift_left ? shift_src[7] : shift_src[0];

    assign inc_res = m + 8'd1;
    assign dec_res = m - 8'd1;

    // Operation select and register update.
    always_comb begin
        nxt   = i_state;
        wv    = 1'b0;
        wd    = 8'd0;
        stk   = 1'b0;
        slot  = 8'd0;
        taken = 1'b0;
        case (i_req.func)
            F_ORA: begin
                nxt.acc   = i_state.acc | m;
                nxt.flags = f_zn(i_state.flags, i_state.acc | m);
            end
            F_AND: begin
                nxt.acc   = i_state.acc & m;
                nxt.flags = f_zn(i_state.flags, i_state.acc & m);
            end
            F_EOR: begin
                nxt.acc   = i_state.acc ^ m;
                nxt.flags = f_zn(i_state.flags, i_state.acc ^ m);
            end
            F_ADC, F_SBC: begin
                nxt.acc   = sum[7:0];
                nxt.flags = f_zn(i_state.flags, sum[7:0]);
                nxt.flags[FLAG_C] = sum[8];
                nxt.flags[FLAG_V] = (i_state.acc[7] ^ sum[7]) & (addend[7] ^ sum[7]);
            end
            F_CMP, F_CPX, F_CPY: begin
                nxt.flags = f_zn(i_state.flags, diff[7:0]);
                nxt.flags[FLAG_C] = ~diff[8];
            end
            F_BIT: begin
                nxt.flags[FLAG_Z] = ((i_state.acc & m) == 8'd0);
                nxt.flags[FLAG_V] = m[6];
                nxt.flags[FLAG_N] = m[7];
            end
            F_LDA: begin
                nxt.acc   = m;
                nxt.flags = f_zn(i_state.flags, m);
            end
            F_LDX: begin
                nxt.x     = m;
                nxt.flags = f_zn(i_state.flags, m);
            end
            F_LDY: begin
                nxt.y     = m;
                nxt.flags = f_zn(i_state.flags, m);
            end
            F_STA: begin
                wv = 1'b1;
                wd = i_state.acc;
            end
            F_STX: begin
                wv = 1'b1;
                wd = i_state.x;
            end
            F_STY: begin
                wv = 1'b1;
                wd = i_state.y;
            end
            F_ASL, F_ROL, F_LSR, F_ROR: begin
                nxt.flags = f_zn(i_state.flags, shift_res);
                nxt.flags[FLAG_C] = shift_c;
                if (i_req.on_accumulator) begin
                    nxt.acc = shift_res;
                end else begin
                    wv = 1'b1;
                    wd = shift_res;
                end
            end
            F_INC: begin
                nxt.flags = f_zn(i_state.flags, inc_res);
                wv        = 1'b1;
                wd        = inc_res;
            end
            F_DEC: begin
                nxt.flags = f_zn(i_state.flags, dec_res);
                wv        = 1'b1;
                wd        = dec_res;
            end
            F_PHA: begin
                wv     = 1'b1;
                wd     = i_state.acc;
                stk    = 1'b1;
                slot   = i_state.sp;
                nxt.sp = i_state.sp - 8'd1;
            end
            F_PHP: begin
                wv     = 1'b1;
                wd     = i_state.flags | (8'd1 << FLAG_B) | (8'd1 << FLAG_U);
                stk    = 1'b1;
                slot   = i_state.sp;
                nxt.sp = i_state.sp - 8'd1;
            end
            F_PLA: begin
                nxt.sp    = i_state.sp + 8'd1;
                stk       = 1'b1;
                slot      = i_state.sp + 8'd1;
                nxt.acc   = m;
                nxt.flags = f_zn(i_state.flags, m);
            end
            F_PLP: begin
                nxt.sp    = i_state.sp + 8'd1;
                stk       = 1'b1;
                slot      = i_state.sp + 8'd1;
                nxt.flags = m;
                nxt.flags[FLAG_B] = 1'b0;
                nxt.flags[FLAG_U] = 1'b1;
            end
            F_TAX: begin
                nxt.x     = i_state.acc;
                nxt.flags = f_zn(i_state.flags, i_state.acc);
            end
            F_TAY: begin
                nxt.y     = i_state.acc;
                nxt.flags = f_zn(i_state.flags, i_state.acc);
            end
            F_TXA: begin
                nxt.acc   = i_state.x;
                nxt.flags = f_zn(i_state.flags, i_state.x);
            end
            F_TYA: begin
                nxt.acc   = i_state.y;
                nxt.flags = f_zn(i_state.flags, i_state.y);
            end
            F_TSX: begin
                nxt.x     = i_state.sp;
                nxt.flags = f_zn(i_state.flags, i_state.sp);
            end
            F_TXS: begin
                nxt.sp = i_state.x;
            end
            F_INX: begin
                nxt.x     = i_state.x + 8'd1;
                nxt.flags = f_zn(i_state.flags, i_state.x + 8'd1);
            end
            F_INY: begin
                nxt.y     = i_state.y + 8'd1;
                nxt.flags = f_zn(i_state.flags, i_state.y + 8'd1);
            end
            F_DEX: begin
                nxt.x     = i_state.x - 8'd1;
                nxt.flags = f_zn(i_state.flags, i_state.x - 8'd1);
            end
            F_DEY: begin
                nxt.y     = i_state.y - 8'd1;
                nxt.flags = f_zn(i_state.flags, i_state.y - 8'd1);
            end
            F_CLC: nxt.flags[FLAG_C] = 1'b0;
            F_SEC: nxt.flags[FLAG_C] = 1'b1;
            F_CLI: nxt.flags[FLAG_I] = 1'b0;
            F_SEI: nxt.flags[FLAG_I] = 1'b1;
            F_CLD: nxt.flags[FLAG_D] = 1'b0;
            F_SED: nxt.flags[FLAG_D] = 1'b1;
            F_CLV: nxt.flags[FLAG_V] = 1'b0;
            F_BPL: taken = ~i_state.flags[FLAG_N];
            F_BMI: taken = i_state.flags[FLAG_N];
            F_BVC: taken = ~i_state.flags[FLAG_V];
            F_BVS: taken = i_state.flags[FLAG_V];
            F_BCC: taken = ~i_state.flags[FLAG_C];
            F_BCS: taken = i_state.flags[FLAG_C];
            F_BNE: taken = ~i_state.flags[FLAG_Z];
            F_BEQ: taken = i_state.flags[FLAG_Z];
            F_NOP: ;
            default: ;
        endcase
    end

    assign o_state = nxt;

    // The result carries the updated registers with the side outputs.
    assign o_result.acc          = nxt.acc;
    assign o_result.index_x      = nxt.x;
    assign o_result.index_y      = nxt.y;
    assign o_result.stack_ptr    = nxt.sp;
    assign o_result.status       = nxt.flags;
    assign o_result.write_valid  = wv;
    assign o_result.write_data   = wd;
    assign o_result.to_stack     = stk;
    assign o_result.stack_slot   = slot;
    assign o_result.branch_taken = taken;

endmodule

`default_nettype wire

### hdl/cpu6502_execute_unit.sv
// Top level of the 6502 execute unit: input register, register file and result register.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-----------------------
//   request  | in        | i_in_valid / o_in_ready    | i_in_data  (t_c65_in)
//   result   | out       | o_out_valid / i_out_ready  | o_out_data (t_c65_out)
//
// One request is taken per cycle while o_in_ready is high; its result is held in r_out.
// The rate is set by the single ALU pass in c65_exec between the input and result registers.
// Reset clears A, X and Y, sets SP to 0xFD and the flags to 0x24, and empties both stages.
// A stalled result holds in the output register; o_in_ready drops only when both
// stages are full and the result is not taken.
`timescale 1ns / 1ps
`default_nettype none

module cpu6502_execute_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  c65_pkg::t_c65_in   i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output c65_pkg::t_c65_out  o_out_data
);
    import c65_pkg::*;

    logic       r_in_valid;
    t_c65_in    r_in;
    t_c65_state r_state;
    logic       r_out_valid;
    t_c65_out   r_out;

    t_c65_state state_next;
    t_c65_out   result;
    logic       out_free;
    logic       advance;

    assign out_free   = ~r_out_valid | i_out_ready;
    assign advance    = r_in_valid & out_free;
    assign o_in_ready = ~r_in_valid | out_free;

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // ALU and register update.
    c65_exec u_exec (
        .i_req    (r_in),
        .i_state  (r_state),
        .o_state  (state_next),
        .o_result (result)
    );

    // Architectural registers change when a request moves into the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.acc   <= 8'd0;
            r_state.x     <= 8'd0;
            r_state.y     <= 8'd0;
            r_state.sp    <= RESET_SP;
            r_state.flags <= RESET_FLAGS;
        end else if (advance) begin
            r_state <= state_next;
        end
    end

    // Result register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // A request in the input stage with room downstream shows up as a result next cycle.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("request did not reach the result stage");

    // The pending result always matches the register file it left behind.
    a_state_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.acc == r_state.acc) && (r_out.index_x == r_state.x) &&
                        (r_out.index_y == r_state.y) && (r_out.stack_ptr == r_state.sp) &&
                        (r_out.status == r_state.flags))
        else $error("result registers disagree with register file");

    // The flag byte keeps the unused bit set and the break bit clear.
    a_flag_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.flags[FLAG_U] && !r_state.flags[FLAG_B])
        else $error("fixed flag bits corrupted");

    // Side outputs are zero when their qualifier is low.
    a_side_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.write_valid || r_out.write_data == 8'd0) &&
                        (r_out.to_stack || r_out.stack_slot == 8'd0))
        else $error("unqualified side output not zero");
`endif

endmodule

`default_nettype wire

### verif/tb_cpu6502_execute_unit.sv
// Self-checking testbench for the 6502 execute unit: directed table, random requests, predictor.
`timescale 1ns / 1ps

module tb_cpu6502_execute_unit;

    import c65_pkg::*;

    // Codes 51 to 63 are not operations and must behave as NOP.
    localparam logic [5:0] UNKNOWN_FUNC = 6'd63;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 550;
    localparam int LONG_HOLD     = 80;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;

    localparam t_c65_out NO_GOLDEN = '0;

    // One row of the directed table; golden is used only where known is set.
    typedef struct packed {
        t_c65_in  req;
        logic     known;
        t_c65_out golden;
    } t_directed_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_c65_in    i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_c65_out   o_out_data;

    t_c65_state arch_regs;
    t_c65_out   pending_results [$];
    int         error_count  = 0;
    int         cycle_count  = 0;
    bit         hold_off_req = 1'b0;
    bit         sink_quiet   = 1'b0;

    cpu6502_execute_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Free-running 10 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Z and N follow the value just produced.
    function automatic void set_zn(input logic [7:0] v);
        arch_regs.flags[FLAG_Z] = (v == 8'h00);
        arch_regs.flags[FLAG_N] = v[7];
    endfunction

    // Compare sets C on no borrow and Z/N from the difference.
    function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
        arch_regs.flags[FLAG_C] = (r >= m);
        set_zn(r - m);
    endfunction

    // Binary add with carry in; SBC passes the inverted operand.
    function automatic logic [7:0] add_with_carry(input logic [7:0] addend);
        logic [8:0] sum;
        logic [7:0] r;
        sum = {1'b0, arch_regs.acc} + {1'b0, addend} + {8'h00, arch_regs.flags[FLAG_C]};
        r = sum[7:0];
        arch_regs.flags[FLAG_C] = sum[8];
        arch_regs.flags[FLAG_V] = ((arch_regs.acc ^ r) & (addend ^ r) & 8'h80) != 8'h00;
        set_zn(r);
        return r;
    endfunction

    // Predicts the result of one request and advances the architectural registers.
    task automatic predict_request(input t_c65_in req, output t_c65_out res);
        logic [7:0] m;
        logic [7:0] src;
        logic [7:0] r;
        logic       cin;
        m   = req.operand;
        cin = arch_regs.flags[FLAG_C];
        res = '0;
        case (req.func)
            F_ORA: begin arch_regs.acc = arch_regs.acc | m; set_zn(arch_regs.acc); end
            F_AND: begin arch_regs.acc = arch_regs.acc & m; set_zn(arch_regs.acc); end
            F_EOR: begin arch_regs.acc = arch_regs.acc ^ m; set_zn(arch_regs.acc); end
            F_ADC: arch_regs.acc = add_with_carry(m);
            F_SBC: arch_regs.acc = add_with_carry(~m);
            F_CMP: compare_reg(arch_regs.acc, m);
            F_CPX: compare_reg(arch_regs.x, m);
            F_CPY: compare_reg(arch_regs.y, m);
            F_BIT: begin
                arch_regs.flags[FLAG_Z] = ((arch_regs.acc & m) == 8'h00);
                arch_regs.flags[FLAG_V] = m[6];
                arch_regs.flags[FLAG_N] = m[7];
            end
            F_LDA: begin arch_regs.acc = m; set_zn(m); end
            F_LDX: begin arch_regs.x = m; set_zn(m); end
            F_LDY: begin arch_regs.y = m; set_zn(m); end
            F_STA: begin res.write_valid = 1'b1; res.write_data = arch_regs.acc; end
            F_STX: begin res.write_valid = 1'b1; res.write_data = arch_regs.x; end
            F_STY: begin res.write_valid = 1'b1; res.write_data = arch_regs.y; end
            F_ASL, F_ROL, F_LSR, F_ROR: begin
                src = req.on_accumulator ? arch_regs.acc : m;
                if (req.func == F_ASL || req.func == F_ROL) begin
                    arch_regs.flags[FLAG_C] = src[7];
                    r = {src[6:0], (req.func == F_ROL) & cin};
                end else begin
                    arch_regs.flags[FLAG_C] = src[0];
                    r = {(req.func == F_ROR) & cin, src[7:1]};
                end
                set_zn(r);
                if (req.on_accumulator) begin
                    arch_regs.acc = r;
                end else begin
                    res.write_valid = 1'b1;
                    res.write_data  = r;
                end
            end
            F_INC: begin
                r = m + 8'h01;
                set_zn(r);
                res.write_valid = 1'b1;
                res.write_data  = r;
            end
            F_DEC: begin
                r = m - 8'h01;
                set_zn(r);
                res.write_valid = 1'b1;
                res.write_data  = r;
            end
            // Pushes use the old stack pointer as the slot, pulls the new one.
            F_PHA: begin
                res.write_valid = 1'b1;
                res.write_data  = arch_regs.acc;
                res.to_stack    = 1'b1;
                res.stack_slot  = arch_regs.sp;
                arch_regs.sp    = arch_regs.sp - 8'h01;
            end
            F_PHP: begin
                r = arch_regs.flags;
                r[FLAG_B] = 1'b1;
                r[FLAG_U] = 1'b1;
                res.write_valid = 1'b1;
                res.write_data  = r;
                res.to_stack    = 1'b1;
                res.stack_slot  = arch_regs.sp;
                arch_regs.sp    = arch_regs.sp - 8'h01;
            end
            F_PLA: begin
                arch_regs.sp   = arch_regs.sp + 8'h01;
                res.to_stack   = 1'b1;
                res.stack_slot = arch_regs.sp;
                arch_regs.acc  = m;
                set_zn(m);
            end
            F_PLP: begin
                arch_regs.sp   = arch_regs.sp + 8'h01;
                res.to_stack   = 1'b1;
                res.stack_slot = arch_regs.sp;
                arch_regs.flags = m;
                arch_regs.flags[FLAG_B] = 1'b0;
                arch_regs.flags[FLAG_U] = 1'b1;
            end
            F_TAX: begin arch_regs.x = arch_regs.acc; set_zn(arch_regs.x); end
            F_TAY: begin arch_regs.y = arch_regs.acc; set_zn(arch_regs.y); end
            F_TXA: begin arch_regs.acc = arch_regs.x; set_zn(arch_regs.acc); end
            F_TYA: begin arch_regs.acc = arch_regs.y; set_zn(arch_regs.acc); end
            F_TSX: begin arch_regs.x = arch_regs.sp; set_zn(arch_regs.x); end
            F_TXS: arch_regs.sp = arch_regs.x;
            F_INX: begin arch_regs.x = arch_regs.x + 8'h01; set_zn(arch_regs.x); end
            F_INY: begin arch_regs.y = arch_regs.y + 8'h01; set_zn(arch_regs.y); end
            F_DEX: begin arch_regs.x = arch_regs.x - 8'h01; set_zn(arch_regs.x); end
            F_DEY: begin arch_regs.y = arch_regs.y - 8'h01; set_zn(arch_regs.y); end
            F_CLC: arch_regs.flags[FLAG_C] = 1'b0;
            F_SEC: arch_regs.flags[FLAG_C] = 1'b1;
            F_CLI: arch_regs.flags[FLAG_I] = 1'b0;
            F_SEI: arch_regs.flags[FLAG_I] = 1'b1;
            F_CLD: arch_regs.flags[FLAG_D] = 1'b0;
            F_SED: arch_regs.flags[FLAG_D] = 1'b1;
            F_CLV: arch_regs.flags[FLAG_V] = 1'b0;
            F_BPL: res.branch_taken = ~arch_regs.flags[FLAG_N];
            F_BMI: res.branch_taken =  arch_regs.flags[FLAG_N];
            F_BVC: res.branch_taken = ~arch_regs.flags[FLAG_V];
            F_BVS: res.branch_taken =  arch_regs.flags[FLAG_V];
            F_BCC: res.branch_taken = ~arch_regs.flags[FLAG_C];
            F_BCS: res.branch_taken =  arch_regs.flags[FLAG_C];
            F_BNE: res.branch_taken = ~arch_regs.flags[FLAG_Z];
            F_BEQ: res.branch_taken =  arch_regs.flags[FLAG_Z];
            default: ;
        endcase
        res.acc       = arch_regs.acc;
        res.index_x   = arch_regs.x;
        res.index_y   = arch_regs.y;
        res.stack_ptr = arch_regs.sp;
        res.status    = arch_regs.flags;
    endtask

    // Mostly short gaps, some medium, a few long; none in a calm stretch.
    function automatic int idle_cycles(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        error_count++;
        if (error_count <= 40) begin
            $display("[%0t] mismatch on %s: got %02h, expected %02h", $time, field, got, want);
        end
    endtask

    // Compares one accepted result with the oldest outstanding expectation.
    task automatic check_result(input t_c65_out got);
        t_c65_out want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with no request outstanding, acc", got.acc, 8'h00);
        end else begin
            want = pending_results.pop_front();
            if (got.acc !== want.acc) report_mismatch("acc", got.acc, want.acc);
            if (got.index_x !== want.index_x) report_mismatch("index_x", got.index_x, want.index_x);
            if (got.index_y !== want.index_y) report_mismatch("index_y", got.index_y, want.index_y);
            if (got.stack_ptr !== want.stack_ptr) begin
                report_mismatch("stack_ptr", got.stack_ptr, want.stack_ptr);
            end
            if (got.status !== want.status) report_mismatch("status", got.status, want.status);
            if (got.write_valid !== want.write_valid) begin
                report_mismatch("write_valid", {7'd0, got.write_valid},
                                {7'd0, want.write_valid});
            end
            if (got.write_data !== want.write_data) begin
                report_mismatch("write_data", got.write_data, want.write_data);
            end
            if (got.to_stack !== want.to_stack) begin
                report_mismatch("to_stack", {7'd0, got.to_stack}, {7'd0, want.to_stack});
            end
            if (got.stack_slot !== want.stack_slot) begin
                report_mismatch("stack_slot", got.stack_slot, want.stack_slot);
            end
            if (got.branch_taken !== want.branch_taken) begin
                report_mismatch("branch_taken", {7'd0, got.branch_taken},
                                {7'd0, want.branch_taken});
            end
        end
    endtask

    // Holds one request on the input until it is accepted, then records its expectation.
    task automatic offer_request(input t_c65_in req, input t_c65_out golden, input logic known);
        t_c65_out predicted;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predict_request(req, predicted);
        pending_results.push_back(known ? golden : predicted);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin : result_sink
        int n;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                n = LONG_HOLD;
            end else begin
                n = idle_cycles(sink_quiet);
                i_out_ready <= (n == 0);
                if (n == 0) n = 1;
            end
            repeat (n) @(posedge i_clk);
        end
    end

    // Result monitor.
    initial begin : result_monitor
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_result(o_out_data);
        end
    end

    // Watchdog.
    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stimulus: directed table first, then random requests.
    initial begin : stimulus
        t_directed_row directed_table [DIRECTED_ROWS];
        t_c65_in       req;
        int            roll;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        arch_regs = {8'h00, 8'h00, 8'h00, RESET_SP, RESET_FLAGS};
        directed_table = '{
            // NOP right after reset shows the reset register values.
            {F_NOP, 8'h00, 1'b0, 1'b1,
             {8'h00, 8'h00, 8'h00, RESET_SP, RESET_FLAGS, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0}},
            {F_LDA, 8'h80, 1'b0, 1'b1,
             {8'h80, 8'h00, 8'h00, 8'hFD, 8'hA4, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0}},
            // An unknown code changes nothing.
            {UNKNOWN_FUNC, 8'hFF, 1'b1, 1'b1,
             {8'h80, 8'h00, 8'h00, 8'hFD, 8'hA4, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0}},
            // PHP pushes the flags with B and bit five set.
            {F_PHP, 8'h00, 1'b0, 1'b1,
             {8'h80, 8'h00, 8'h00, 8'hFC, 8'hA4, 1'b1, 8'hB4, 1'b1, 8'hFD, 1'b0}},
            // PLP drops B and forces bit five.
            {F_PLP, 8'hFF, 1'b0, 1'b1,
             {8'h80, 8'h00, 8'h00, 8'hFD, 8'hEF, 1'b0, 8'h00, 1'b1, 8'hFD, 1'b0}},
            {F_ADC, 8'hFF, 1'b0, 1'b0, NO_GOLDEN},
            {F_SBC, 8'h00, 1'b0, 1'b0, NO_GOLDEN},
            {F_ADC, 8'h7F, 1'b0, 1'b0, NO_GOLDEN},
            {F_BIT, 8'hC0, 1'b0, 1'b0, NO_GOLDEN},
            {F_CMP, 8'h80, 1'b0, 1'b0, NO_GOLDEN},
            // Stack pointer wraps both ways through zero.
            {F_LDX, 8'h00, 1'b0, 1'b0, NO_GOLDEN},
            {F_TXS, 8'h00, 1'b0, 1'b0, NO_GOLDEN},
            {F_PHA, 8'h00, 1'b0, 1'b0, NO_GOLDEN},
            {F_PLA, 8'h00, 1'b0, 1'b0, NO_GOLDEN},
            {F_ROL, 8'h00, 1'b1, 1'b0, NO_GOLDEN},
            {F_ROR, 8'h01, 1'b0, 1'b0, NO_GOLDEN},
            {F_INC, 8'hFF, 1'b0, 1'b0, NO_GOLDEN},
            {F_DEC, 8'h00, 1'b0, 1'b0, NO_GOLDEN},
            {F_SED, 8'h00, 1'b0, 1'b0, NO_GOLDEN},
            {F_LSR, 8'hFF, 1'b1, 1'b0, NO_GOLDEN},
            {F_BEQ, 8'h00, 1'b0, 1'b0, NO_GOLDEN},
            {F_BCS, 8'h00, 1'b0, 1'b0, NO_GOLDEN},
            // The accumulator select is ignored outside shifts and rotates.
            {F_STA, 8'hFF, 1'b1, 1'b0, NO_GOLDEN},
            {F_CPY, 8'hFF, 1'b0, 1'b0, NO_GOLDEN},
            {F_TSX, 8'h00, 1'b0, 1'b0, NO_GOLDEN}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_table[k]) begin
            offer_request(directed_table[k].req, directed_table[k].golden,
                          directed_table[k].known);
            pause_sender(idle_cycles(1'b0));
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // Long receiver hold-off while the sender streams without gaps.
            if (k == 150) hold_off_req = 1'b1;
            sink_quiet = (k >= 400 && k < 450);
            roll = $urandom_range(0, 99);
            req.func = (roll < 94) ? 6'($urandom_range(0, 50)) : 6'($urandom_range(51, 63));
            roll = $urandom_range(0, 9);
            case (roll)
                0:       req.operand = 8'h00;
                1:       req.operand = 8'hFF;
                2:       req.operand = $urandom_range(0, 1) ? 8'h7F : 8'h80;
                default: req.operand = 8'($urandom_range(0, 255));
            endcase
            req.on_accumulator = 1'($urandom_range(0, 1));
            offer_request(req, NO_GOLDEN, 1'b0);
            // Once midway and at the end, the sender waits for every result.
            if (k == 299 || k == RANDOM_ITEMS - 1) begin
                i_in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end else begin
                pause_sender(idle_cycles((k >= 150 && k < 180) || sink_quiet));
            end
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### cpu6502_execute_unit.f
hdl/c65_pkg.sv
hdl/c65_exec.sv
hdl/cpu6502_execute_unit.sv
verif/tb_cpu6502_execute_unit.sv
